[sv/sbph_pkg.sv]
// sbph_pkg: shared types, constants and register indexes for the band peak-hold block
// no dependencies

package sbph_pkg;

  // default sizes, handed down as parameters from the top level
  localparam int MAX_BANDS_DEF = 64;
  localparam int MAX_GROUP_DEF = 16;
  localparam int MAG_WIDTH_DEF = 24;

  // fixed field widths
  localparam int MAG_FIELD_W = 24;
  localparam int BIN_W       = 11;
  localparam int LEVEL_W     = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [BIN_W-1:0]   BIN_FULL   = 11'd2047;
  localparam logic [LEVEL_W-1:0] LEVEL_CEIL = 12'd2048;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BAND       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_END         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP       = 2'd3;

  typedef struct packed {
    logic [MAG_FIELD_W-1:0] magnitude;
    logic                   frame_start;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         band_index;
    logic [LEVEL_W-1:0] band_level;
    logic               last_band;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // input transaction accepted this cycle
    logic div_start;   // load the divider
    logic div_resync;  // divider works on the bin count, not the group sum
    logic rs_load;     // load band and position from the divider
    logic update;      // write the new level and hand the result out
  } sbph_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;        // the offered bin closes a band in range
    logic div_done;    // divider result ready this cycle
  } sbph_stat_t;

endpackage

[sv/sbph_div.sv]
// sbph_div: restoring divider, one quotient bit per cycle, with clamp on large quotients
// depends on sbph_pkg

module sbph_div import sbph_pkg::*; #(
  parameter int DVD_W = 29,
  parameter int GRP_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [GRP_W-1:0]   divisor,
  output logic               done,
  output logic [LEVEL_W-1:0] quot,
  output logic [BIN_W-1:0]   quot_bin,
  output logic [GRP_W-1:0]   rem
);

  localparam int HI_W  = DVD_W - BIN_W;
  localparam int CMP_W = HI_W + GRP_W;
  localparam int CNT_W = $clog2(BIN_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             clamp_r, clamp_nxt;
  logic [GRP_W-1:0] dvs_r, dvs_nxt;
  logic [GRP_W-1:0] rem_r, rem_nxt;
  logic [BIN_W-1:0] lo_r, lo_nxt;
  logic [BIN_W-1:0] q_r, q_nxt;

  logic [HI_W-1:0]  hi;
  logic             big;
  logic [GRP_W:0]   trial;
  logic             fits;

  assign hi    = dividend[DVD_W-1:BIN_W];
  // quotient would reach 2^BIN_W or more: saturate
  assign big   = CMP_W'(hi) >= CMP_W'(divisor);
  assign trial = {rem_r, lo_r[BIN_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  assign done     = busy_r && (cnt_r == '0);
  assign quot     = clamp_r ? LEVEL_CEIL : LEVEL_W'(q_r);
  assign quot_bin = q_r;
  assign rem      = rem_r;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    clamp_nxt = clamp_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    if (start) begin
      busy_nxt  = 1'b1;
      clamp_nxt = big;
      cnt_nxt   = big ? '0 : CNT_W'(BIN_W);
      dvs_nxt   = divisor;
      rem_nxt   = hi[GRP_W-1:0];
      lo_nxt    = dividend[BIN_W-1:0];
      q_nxt     = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = fits ? GRP_W'(trial - {1'b0, dvs_r}) : trial[GRP_W-1:0];
      lo_nxt  = {lo_r[BIN_W-2:0], 1'b0};
      q_nxt   = {q_r[BIN_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clamp_r <= clamp_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    lo_r    <= lo_nxt;
    q_r     <= q_nxt;
  end

endmodule

[sv/sbph_dp.sv]
// sbph_dp: bin counters, group sum, divider and band level store
// depends on sbph_pkg and sbph_div

module sbph_dp import sbph_pkg::*; #(
  parameter int MAX_BANDS = MAX_BANDS_DEF,
  parameter int MAX_GROUP = MAX_GROUP_DEF,
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  sbph_cmd_t    cmd,
  output sbph_stat_t   stat,
  input  in_item_t     in_data,
  input  logic [4:0]   samples_per_band,
  input  logic [5:0]   first_band,
  input  logic [6:0]   band_end,
  input  logic [11:0]  decay_step,
  output out_item_t    res
);

  localparam int MAG_USE = (MAG_WIDTH < MAG_FIELD_W) ? MAG_WIDTH : MAG_FIELD_W;
  localparam int SUM_W   = ((MAG_USE > LEVEL_W) ? MAG_USE : LEVEL_W) + $clog2(MAX_GROUP);
  localparam int GRP_W   = $clog2(MAX_GROUP + 1);
  localparam int GC_W    = (GRP_W > 5) ? GRP_W : 5;
  localparam int IDX_W   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int DVD_W   = ((SUM_W > BIN_W) ? SUM_W : BIN_W) + 1;
  localparam logic [GC_W-1:0]  MAXG = GC_W'(MAX_GROUP);
  localparam logic [BIN_W-1:0] MAXB = BIN_W'(MAX_BANDS);

  logic [BIN_W-1:0] bin_count_r, bin_count_nxt;
  logic [BIN_W-1:0] band_r, band_nxt;
  logic [GRP_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic [IDX_W-1:0] rel_r;
  logic [5:0]       idx_r;
  logic             last_r;
  logic [LEVEL_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [MAX_BANDS-1:0] vld_r;
  logic [LEVEL_W-1:0] lvl_mem [MAX_BANDS];

  logic [GC_W-1:0]  spb_x;
  logic [GRP_W-1:0] grp;
  logic [BIN_W-1:0] end_w;
  logic [BIN_W-1:0] bc, band_c, rel_c;
  logic [GRP_W-1:0] pos_c;
  logic [SUM_W-1:0] sum_c, sum_base, sum_new;
  logic [SUM_W:0]   sum_wide;
  logic             full, in_range, closes, last_c;
  logic [DVD_W-1:0] dividend;

  logic               div_done;
  logic [LEVEL_W-1:0] avg;
  logic [BIN_W-1:0]   q_bin;
  logic [GRP_W-1:0]   q_rem;

  logic [LEVEL_W-1:0] lvl_old, lvl_dec, lvl_new;

  // effective group size and band end
  assign spb_x = GC_W'(samples_per_band);
  assign grp   = (spb_x == '0) ? GRP_W'(1) : ((spb_x > MAXG) ? GRP_W'(MAX_GROUP) :
                 GRP_W'(spb_x));
  assign end_w = (BIN_W'(band_end) > MAXB) ? MAXB : BIN_W'(band_end);

  // frame start restarts the count before the bin is taken
  assign bc     = in_data.frame_start ? '0 : bin_count_r;
  assign band_c = in_data.frame_start ? '0 : band_r;
  assign pos_c  = in_data.frame_start ? '0 : pos_r;
  assign sum_c  = in_data.frame_start ? '0 : sum_r;

  assign full     = bc >= BIN_FULL;
  assign in_range = (band_c >= BIN_W'(first_band)) && (band_c < end_w);
  assign closes   = pos_c == (grp - 1'b1);
  assign sum_base = (pos_c == '0) ? '0 : sum_c;
  assign sum_wide = {1'b0, sum_base} +
                    {{(SUM_W + 1 - MAG_USE){1'b0}}, in_data.magnitude[MAG_USE-1:0]};
  // saturate: a sum past the top already clamps the average at the ceiling
  assign sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign rel_c    = band_c - BIN_W'(first_band);
  assign last_c   = band_c == (end_w - 1'b1);

  assign stat.emit     = !full && in_range && closes;
  assign stat.div_done = div_done;

  assign dividend = cmd.div_resync ? DVD_W'(bin_count_r) : DVD_W'(sum_new);

  sbph_div #(
    .DVD_W (DVD_W),
    .GRP_W (GRP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (grp),
    .done     (div_done),
    .quot     (avg),
    .quot_bin (q_bin),
    .rem      (q_rem)
  );

  always_comb begin
    bin_count_nxt = bin_count_r;
    band_nxt      = band_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    if (cmd.rs_load) begin
      band_nxt = q_bin;
      pos_nxt  = q_rem;
    end else if (cmd.take) begin
      bin_count_nxt = bc;
      band_nxt      = band_c;
      pos_nxt       = pos_c;
      sum_nxt       = sum_c;
      if (!full) begin
        bin_count_nxt = bc + 1'b1;
        if (closes) begin
          pos_nxt  = '0;
          band_nxt = band_c + 1'b1;
        end else begin
          pos_nxt = pos_c + 1'b1;
        end
        if (in_range) begin
          sum_nxt = closes ? '0 : sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= '0;
      band_r      <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
    end else begin
      bin_count_r <= bin_count_nxt;
      band_r      <= band_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // level update: decay with floor at zero, then peak compare
  assign lvl_old = rd_vld_r ? rd_data_r : '0;
  assign lvl_dec = (lvl_old > decay_step) ? (lvl_old - decay_step) : '0;
  assign lvl_new = (avg > lvl_dec) ? avg : lvl_dec;

  always_ff @(posedge clk) begin
    if (cmd.take && stat.emit) begin
      rd_data_r <= lvl_mem[rel_c[IDX_W-1:0]];
      rel_r     <= rel_c[IDX_W-1:0];
      idx_r     <= rel_c[5:0];
      last_r    <= last_c;
    end
    if (cmd.update) begin
      lvl_mem[rel_r] <= lvl_new;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.take && stat.emit) begin
        rd_vld_r <= vld_r[rel_c[IDX_W-1:0]];
      end
      if (cmd.update) begin
        vld_r[rel_r] <= 1'b1;
      end
    end
  end

  assign res.band_index = idx_r;
  assign res.band_level = lvl_new;
  assign res.last_band  = last_r;

endmodule

[sv/sbph_ctrl.sv]
// sbph_ctrl: sequencing of bin intake, division and level update
// depends on sbph_pkg

module sbph_ctrl import sbph_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cfg_valid,
  input  logic       grp_wr,
  input  logic       out_free,
  input  sbph_stat_t stat,
  output sbph_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV_RS = 2'd1;
  localparam logic [1:0] ST_DIV_AV = 2'd2;
  localparam logic [1:0] ST_UPD    = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       resync_r, resync_nxt;
  logic       rs_go;

  // group size changed: redo band and position from the bin count
  assign rs_go = (state_r == ST_IDLE) && resync_r && !cfg_valid;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !resync_r && !cfg_valid;
        if (rs_go) begin
          cmd.div_start  = 1'b1;
          cmd.div_resync = 1'b1;
          state_nxt      = ST_DIV_RS;
        end else if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (stat.emit) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV_AV;
          end
        end
      end
      ST_DIV_RS: begin
        if (stat.div_done) begin
          cmd.rs_load = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_DIV_AV: begin
        if (stat.div_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign resync_nxt = grp_wr || (resync_r && !rs_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      resync_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      resync_r <= resync_nxt;
    end
  end

endmodule

[sv/spectrum_band_peak_hold.sv]
// spectrum_band_peak_hold: top level with configuration registers and result register
// depends on sbph_pkg, sbph_ctrl, sbph_dp (and sbph_div below it)
//
// usage
//  - in_*: one fft magnitude bin per transaction; frame_start marks bin zero of a frame
//  - bins are grouped into bands of samples_per_band; bands outside
//    [first_band, band_end) are dropped
//  - out_*: one transaction per closed band in range, carrying the band number
//    relative to first_band, its new peak-hold level (0..2048) and a last-band flag
//  - cfg_*: register writes, index 0..3 = samples_per_band, first_band, band_end,
//    decay_step; always ready, write only while no bin is in flight
// timing
//  - a bin that does not close a band is taken with no division; input stays ready
//  - a bin that closes a band passes through intake, the 11 quotient bits from
//    the radix-2 divider, its done step and the level update; the quotient bits
//    are skipped if the average clamps, and no further bin is taken until the update
//  - a write to samples_per_band starts a pass of the same divider that
//    rebuilds the band and position counters; no bin is taken meanwhile
// reset
//  - counters, sums and all band levels clear, registers take their defaults
// stalls
//  - the result register holds a finished band while bins keep flowing; only the
//    next band update waits for out_ready

module spectrum_band_peak_hold import sbph_pkg::*; #(
  parameter int MAX_BANDS = MAX_BANDS_DEF,
  parameter int MAX_GROUP = MAX_GROUP_DEF,
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [4:0]  samples_per_band_r;
  logic [5:0]  first_band_r;
  logic [6:0]  band_end_r;
  logic [11:0] decay_step_r;

  logic        grp_wr;
  logic        out_free;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  out_item_t   res;
  sbph_cmd_t   cmd;
  sbph_stat_t  stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;
  assign grp_wr    = cfg_valid && (cfg_index == CFG_SAMPLES_PER_BAND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_per_band_r <= 5'd4;
      first_band_r       <= 6'd0;
      band_end_r         <= 7'd32;
      decay_step_r       <= 12'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SAMPLES_PER_BAND: samples_per_band_r <= cfg_data[4:0];
        CFG_FIRST_BAND:       first_band_r       <= cfg_data[5:0];
        CFG_BAND_END:         band_end_r         <= cfg_data[6:0];
        CFG_DECAY_STEP:       decay_step_r       <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  sbph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .grp_wr    (grp_wr),
    .out_free  (out_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbph_dp #(
    .MAX_BANDS (MAX_BANDS),
    .MAX_GROUP (MAX_GROUP),
    .MAG_WIDTH (MAG_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_data          (in_data),
    .samples_per_band (samples_per_band_r),
    .first_band       (first_band_r),
    .band_end         (band_end_r),
    .decay_step       (decay_step_r),
    .res              (res)
  );

  // result register: frees up as soon as the current transaction is taken
  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = cmd.update ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
